FILE: rtl/vsoc_pkg.sv
// Shared types, widths, constants and voltage tables of the state-of-charge estimator.
package vsoc_pkg;

  localparam int TableEntries = 15;
  localparam int IdxW = $clog2(TableEntries);

  localparam int VinW   = 16;
  localparam int TempW  = 16;
  localparam int CurW   = 16;
  localparam int SocOutW = 7;
  localparam int VfW    = 24;
  localparam int SocW   = 16;
  localparam int FracW  = 8;

  localparam int LimitW = 16;
  localparam int GainW  = 9;
  localparam int StepW  = 15;
  localparam int TcoW   = 10;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int CvW  = 11;
  localparam int PctW = 7;

  localparam int VW    = 26;
  localparam int MulAW = 26;
  localparam int MulBW = 11;
  localparam int ProdW = MulAW + MulBW;

  localparam int NumW = 17;
  localparam int DenW = 6;

  localparam logic [LimitW-1:0] IdleLimitReset = LimitW'(250);
  localparam logic [GainW-1:0]  GainReset      = GainW'(128);
  localparam logic [GainW-1:0]  GainUnity      = GainW'(256);
  localparam logic [StepW-1:0]  StepReset      = StepW'(256);
  localparam logic [TcoW-1:0]   TcoReset       = TcoW'(98);

  localparam logic signed [TempW:0]   TempRef   = (TempW+1)'(2500);
  localparam logic signed [ProdW-1:0] CorrRound = ProdW'(128);

  typedef enum logic [CfgIdxW-1:0] {
    CfgIdleLimit  = 2'd0,
    CfgFilterGain = 2'd1,
    CfgMaxStep    = 2'd2,
    CfgTempCoef   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LimitW-1:0] idle_limit;
    logic [GainW-1:0]  filter_gain;
    logic [StepW-1:0]  max_step;
    logic [TcoW-1:0]   temp_coef;
  } cfg_t;

  localparam logic [CvW-1:0] ChargeCv [TableEntries] = '{
    11'd1716, 11'd1705, 11'd1685, 11'd1662, 11'd1630, 11'd1609, 11'd1577, 11'd1555,
    11'd1544, 11'd1534, 11'd1512, 11'd1491, 11'd1469, 11'd1448, 11'd1405};
  localparam logic [PctW-1:0] ChargePct [TableEntries] = '{
    7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd45,
    7'd40, 7'd35, 7'd30, 7'd20, 7'd15, 7'd10, 7'd5};
  localparam logic [CvW-1:0] WorkCv [TableEntries] = '{
    11'd1680, 11'd1632, 11'd1608, 11'd1584, 11'd1560, 11'd1536, 11'd1512, 11'd1488,
    11'd1464, 11'd1440, 11'd1416, 11'd1380, 11'd1344, 11'd1320, 11'd1296};
  localparam logic [PctW-1:0] WorkPct [TableEntries] = '{
    7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
    7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd2, 7'd0};

  function automatic logic [CvW-1:0] table_cv(input logic chg, input logic [IdxW-1:0] idx);
    logic [CvW-1:0] val;
    val = '0;
    if (int'(idx) < TableEntries) begin
      val = chg ? ChargeCv[idx] : WorkCv[idx];
    end
    return val;
  endfunction

  function automatic logic [PctW-1:0] table_pct(input logic chg, input logic [IdxW-1:0] idx);
    logic [PctW-1:0] val;
    val = '0;
    if (int'(idx) < TableEntries) begin
      val = chg ? ChargePct[idx] : WorkPct[idx];
    end
    return val;
  endfunction

endpackage

FILE: rtl/vsoc_if.sv
// Valid/ready channel interfaces for the input word and the result word.
interface vsoc_in_if;
  logic                         valid;
  logic                         ready;
  logic [vsoc_pkg::VinW-1:0]    voltage_cv;
  logic [vsoc_pkg::TempW-1:0]   temperature_cdeg;
  logic [vsoc_pkg::CurW-1:0]    current_ma;
  logic                         is_charging;

  modport source(output valid, voltage_cv, temperature_cdeg, current_ma, is_charging,
                 input ready);
  modport sink(input valid, voltage_cv, temperature_cdeg, current_ma, is_charging,
               output ready);
endinterface

interface vsoc_out_if;
  logic                          valid;
  logic                          ready;
  logic [vsoc_pkg::SocOutW-1:0]  soc_percent;

  modport source(output valid, soc_percent, input ready);
  modport sink(input valid, soc_percent, output ready);
endinterface

FILE: rtl/vsoc_cfg.sv
// Configuration register file with write decode and filter gain saturation.
module vsoc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vsoc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [vsoc_pkg::CfgDataW-1:0]   cfg_data_i,
  output vsoc_pkg::cfg_t                  cfg_o
);

  logic [vsoc_pkg::LimitW-1:0] idle_limit_q;
  logic [vsoc_pkg::GainW-1:0]  gain_q;
  logic [vsoc_pkg::StepW-1:0]  step_q;
  logic [vsoc_pkg::TcoW-1:0]   tco_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= vsoc_pkg::IdleLimitReset;
      gain_q       <= vsoc_pkg::GainReset;
      step_q       <= vsoc_pkg::StepReset;
      tco_q        <= vsoc_pkg::TcoReset;
    end else if (cfg_we_i) begin
      case (vsoc_pkg::cfg_idx_e'(cfg_idx_i))
        vsoc_pkg::CfgIdleLimit:  idle_limit_q <= cfg_data_i[vsoc_pkg::LimitW-1:0];
        vsoc_pkg::CfgFilterGain: gain_q       <= cfg_data_i[vsoc_pkg::GainW-1:0];
        vsoc_pkg::CfgMaxStep:    step_q       <= cfg_data_i[vsoc_pkg::StepW-1:0];
        vsoc_pkg::CfgTempCoef:   tco_q        <= cfg_data_i[vsoc_pkg::TcoW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.idle_limit  = idle_limit_q;
    cfg_o.filter_gain = (gain_q > vsoc_pkg::GainUnity) ? vsoc_pkg::GainUnity : gain_q;
    cfg_o.max_step    = step_q;
    cfg_o.temp_coef   = tco_q;
  end

endmodule

FILE: rtl/vsoc_div.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
module vsoc_div #(
  parameter int NumW = vsoc_pkg::NumW,
  parameter int DenW = vsoc_pkg::DenW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_sh;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
    fits   = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/voltage_soc_estimator_top.sv
// Top level: sequencer and shared multiplier datapath of the state-of-charge estimator.
// A held word (discharging above the idle current) goes from S_IDLE straight to S_DONE.
// A word at a table end passes S_FILT_MUL, S_FILT_ACC, S_CORR and S_CLAMP; an interpolated
// word goes on through S_SEARCH, S_SEG_MUL, S_DIV_GO, S_DIV_WAIT and S_UPDATE.
// One word is in work at a time; the next is taken when the sequencer is back in idle,
// and S_DONE waits until the output register is free.
// Reset restores the register defaults and clears the filter state and the output register.
module voltage_soc_estimator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  vsoc_in_if.sink                         in_if,
  vsoc_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [vsoc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [vsoc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int VW    = vsoc_pkg::VW;
  localparam int ProdW = vsoc_pkg::ProdW;
  localparam int IdxW  = vsoc_pkg::IdxW;
  localparam int CvW   = vsoc_pkg::CvW;
  localparam int PctW  = vsoc_pkg::PctW;
  localparam int SocW  = vsoc_pkg::SocW;
  localparam int FracW = vsoc_pkg::FracW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(vsoc_pkg::TableEntries - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILT_MUL, S_FILT_ACC, S_CORR, S_CLAMP, S_SEARCH,
    S_SEG_MUL, S_DIV_GO, S_DIV_WAIT, S_UPDATE, S_DONE
  } state_e;

  state_e state_q;

  vsoc_pkg::cfg_t cfg;

  logic [vsoc_pkg::VinW-1:0]    vin_q;
  logic [vsoc_pkg::TempW-1:0]   temp_q;
  logic                         chg_q;
  logic [vsoc_pkg::VfW-1:0]     vf_q;
  logic [SocW-1:0]              soc_q;
  logic                         init_q;
  logic signed [VW-1:0]         v_q;
  logic signed [ProdW-1:0]      prod_q;
  logic [IdxW-1:0]              idx_q;
  logic                         out_valid_q;
  logic [vsoc_pkg::SocOutW-1:0] out_soc_q;

  logic signed [vsoc_pkg::MulAW-1:0] mul_a;
  logic signed [vsoc_pkg::MulBW-1:0] mul_b;
  logic signed [ProdW-1:0]           mul_p;

  logic                          in_acc;
  logic [IdxW-1:0]               idx_nx;
  logic signed [VW-1:0]          v_top;
  logic signed [VW-1:0]          v_bot;
  logic signed [VW-1:0]          v_lo;
  logic signed [VW-1:0]          v_off;
  logic [PctW-1:0]               pct_hi;
  logic [PctW-1:0]               pct_lo;
  logic [CvW-1:0]                cv_den;
  logic signed [ProdW-1:0]       filt_step;
  logic signed [ProdW-1:0]       corr;
  logic signed [vsoc_pkg::TempW:0] temp_off;
  logic                          div_start;
  logic                          div_done;
  logic [vsoc_pkg::NumW-1:0]     div_quo;
  logic [SocW-1:0]               soc_new;
  logic signed [SocW:0]          soc_diff;
  logic signed [SocW:0]          soc_lim;
  logic signed [SocW:0]          soc_step;

  vsoc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  vsoc_div #(
    .NumW(vsoc_pkg::NumW),
    .DenW(vsoc_pkg::DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q[vsoc_pkg::NumW-1:0]),
    .den_i  (cv_den[vsoc_pkg::DenW-1:0]),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_if.ready   = (state_q == S_IDLE);
  assign in_acc        = in_if.valid && in_if.ready;
  assign out_if.valid  = out_valid_q;
  assign out_if.soc_percent = out_soc_q;
  assign div_start     = (state_q == S_DIV_GO);

  always_comb begin
    idx_nx   = IdxW'(idx_q + 1'b1);
    v_top    = $signed({{(VW-CvW-FracW){1'b0}}, vsoc_pkg::table_cv(chg_q, '0), {FracW{1'b0}}});
    v_bot    = $signed({{(VW-CvW-FracW){1'b0}}, vsoc_pkg::table_cv(chg_q, LastIdx),
                        {FracW{1'b0}}});
    v_lo     = $signed({{(VW-CvW-FracW){1'b0}}, vsoc_pkg::table_cv(chg_q, idx_nx),
                        {FracW{1'b0}}});
    v_off    = v_q - v_lo;
    pct_hi   = vsoc_pkg::table_pct(chg_q, idx_q);
    pct_lo   = vsoc_pkg::table_pct(chg_q, idx_nx);
    cv_den   = vsoc_pkg::table_cv(chg_q, idx_q) - vsoc_pkg::table_cv(chg_q, idx_nx);
    temp_off = $signed({1'b0, temp_q}) - vsoc_pkg::TempRef;
    filt_step = prod_q >>> FracW;
    corr      = (prod_q + vsoc_pkg::CorrRound) >>> FracW;

    soc_new  = {pct_lo, {FracW{1'b0}}} + SocW'(div_quo);
    soc_diff = $signed({1'b0, soc_new}) - $signed({1'b0, soc_q});
    soc_lim  = $signed({{(SocW+1-vsoc_pkg::StepW){1'b0}}, cfg.max_step});
    if (soc_diff > soc_lim) begin
      soc_step = soc_lim;
    end else if (soc_diff < -soc_lim) begin
      soc_step = -soc_lim;
    end else begin
      soc_step = soc_diff;
    end

    case (state_q)
      S_FILT_MUL: begin
        mul_a = $signed({2'b00, vin_q, {FracW{1'b0}}}) - $signed({2'b00, vf_q});
        mul_b = $signed({2'b00, cfg.filter_gain});
      end
      S_FILT_ACC: begin
        mul_a = vsoc_pkg::MulAW'(temp_off);
        mul_b = $signed({1'b0, cfg.temp_coef});
      end
      S_SEG_MUL: begin
        mul_a = v_off;
        mul_b = $signed({{(vsoc_pkg::MulBW-PctW){1'b0}}, pct_hi - pct_lo});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vin_q  <= in_if.voltage_cv;
      temp_q <= in_if.temperature_cdeg;
      chg_q  <= in_if.is_charging;
    end
    if (state_q == S_FILT_MUL || state_q == S_FILT_ACC || state_q == S_SEG_MUL) begin
      prod_q <= mul_p;
    end
    if (state_q == S_CORR) begin
      v_q <= $signed({2'b00, vf_q}) - corr[VW-1:0];
    end
    if (state_q == S_CLAMP) begin
      idx_q <= '0;
    end else if (state_q == S_SEARCH && !(v_q > v_lo)) begin
      idx_q <= idx_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vf_q        <= '0;
      soc_q       <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_soc_q   <= '0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_if.ready)) begin
        out_valid_q <= 1'b1;
        out_soc_q   <= soc_q[FracW+vsoc_pkg::SocOutW-1:FracW];
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_if.current_ma > cfg.idle_limit && !in_if.is_charging) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_FILT_MUL;
            end
          end
        end
        S_FILT_MUL: begin
          state_q <= S_FILT_ACC;
        end
        S_FILT_ACC: begin
          if (init_q) begin
            vf_q <= vf_q + filt_step[vsoc_pkg::VfW-1:0];
          end else begin
            vf_q <= {vin_q, {FracW{1'b0}}};
          end
          state_q <= S_CORR;
        end
        S_CORR: begin
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          if (v_q >= v_top) begin
            soc_q   <= {vsoc_pkg::table_pct(chg_q, '0), {FracW{1'b0}}} & {SocW{1'b1}};
            state_q <= S_DONE;
          end else if (v_q <= v_bot) begin
            soc_q   <= {vsoc_pkg::table_pct(chg_q, LastIdx), {FracW{1'b0}}} & {SocW{1'b1}};
            state_q <= S_DONE;
          end else begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (v_q > v_lo) begin
            state_q <= S_SEG_MUL;
          end
        end
        S_SEG_MUL: begin
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!init_q) begin
            soc_q  <= soc_new;
            init_q <= 1'b1;
          end else begin
            soc_q <= soc_q + soc_step[SocW-1:0];
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_if.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/tb_voltage_soc_estimator_top.sv
// Self-checking testbench for the state-of-charge estimator with a scoreboard predictor.
`timescale 1ns / 1ps

module tb_voltage_soc_estimator_top;

  localparam int NumPhases     = 8;
  localparam int WordsPerPhase = 100;
  localparam int DrainCycles   = 40;
  localparam int StallLimit    = 2000;

  typedef struct packed {
    logic [vsoc_pkg::VinW-1:0]  voltage_cv;
    logic [vsoc_pkg::TempW-1:0] temperature_cdeg;
    logic [vsoc_pkg::CurW-1:0]  current_ma;
    logic                       is_charging;
  } soc_word_t;

  class soc_scoreboard;
    int idle_limit;
    int filter_gain;
    int max_step;
    int temp_coef;
    longint volt_filt;
    longint soc_est;
    bit primed;
    logic [vsoc_pkg::SocOutW-1:0] soc_expected_q[$];
    int errors;

    function new();
      idle_limit  = int'(vsoc_pkg::IdleLimitReset);
      filter_gain = int'(vsoc_pkg::GainReset);
      max_step    = int'(vsoc_pkg::StepReset);
      temp_coef   = int'(vsoc_pkg::TcoReset);
      volt_filt   = 0;
      soc_est     = 0;
      primed      = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(vsoc_pkg::cfg_idx_e idx, int data);
      case (idx)
        vsoc_pkg::CfgIdleLimit:  idle_limit  = data & 16'hFFFF;
        vsoc_pkg::CfgFilterGain: filter_gain = data & 9'h1FF;
        vsoc_pkg::CfgMaxStep:    max_step    = data & 15'h7FFF;
        vsoc_pkg::CfgTempCoef:   temp_coef   = data & 10'h3FF;
        default: ;
      endcase
    endfunction

    function longint cv_at(bit chg, int i);
      longint val;
      val = chg ? vsoc_pkg::ChargeCv[i] : vsoc_pkg::WorkCv[i];
      return val * 256;
    endfunction

    function longint pct_at(bit chg, int i);
      longint val;
      val = chg ? vsoc_pkg::ChargePct[i] : vsoc_pkg::WorkPct[i];
      return val * 256;
    endfunction

    function logic [vsoc_pkg::SocOutW-1:0] predict_soc(soc_word_t w);
      longint vin_fx, temp, cur, gain, corr, v, v1, v2, s1, s2, soc_new, d;
      bit chg;
      chg = w.is_charging;
      vin_fx = w.voltage_cv;
      vin_fx = vin_fx * 256;
      temp = w.temperature_cdeg;
      cur = w.current_ma;
      if (cur > idle_limit && !chg) begin
        return vsoc_pkg::SocOutW'(soc_est >>> 8);
      end
      if (!primed) begin
        volt_filt = vin_fx;
      end else begin
        gain = (filter_gain > 256) ? 256 : filter_gain;
        volt_filt = volt_filt + ((gain * (vin_fx - volt_filt)) >>> 8);
        volt_filt = volt_filt & 24'hFFFFFF;
      end
      corr = ((temp - 2500) * temp_coef + 128) >>> 8;
      v = volt_filt - corr;
      if (v >= cv_at(chg, 0)) begin
        soc_est = pct_at(chg, 0);
        return vsoc_pkg::SocOutW'(soc_est >>> 8);
      end
      if (v <= cv_at(chg, vsoc_pkg::TableEntries - 1)) begin
        soc_est = pct_at(chg, vsoc_pkg::TableEntries - 1);
        return vsoc_pkg::SocOutW'(soc_est >>> 8);
      end
      soc_new = soc_est;
      for (int i = 0; i < vsoc_pkg::TableEntries - 1; i++) begin
        v1 = cv_at(chg, i);
        v2 = cv_at(chg, i + 1);
        if (v <= v1 && v > v2) begin
          s1 = pct_at(chg, i);
          s2 = pct_at(chg, i + 1);
          soc_new = s2 + ((v - v2) * (s1 - s2)) / (v1 - v2);
          break;
        end
      end
      if (!primed) begin
        soc_est = soc_new;
        primed = 1'b1;
      end else begin
        d = soc_new - soc_est;
        if (d > max_step) d = max_step;
        if (d < -max_step) d = -max_step;
        soc_est = (soc_est + d) & 16'hFFFF;
      end
      return vsoc_pkg::SocOutW'(soc_est >>> 8);
    endfunction

    function void note_word(soc_word_t w);
      soc_expected_q.push_back(predict_soc(w));
    endfunction

    function void check_soc(logic [vsoc_pkg::SocOutW-1:0] actual);
      logic [vsoc_pkg::SocOutW-1:0] expected;
      if (soc_expected_q.size() == 0) begin
        $display("%0t: soc_percent %0d arrived with nothing expected", $time, actual);
        errors++;
      end else begin
        expected = soc_expected_q.pop_front();
        if (actual !== expected) begin
          $display("%0t: soc_percent mismatch, expected %0d, actual %0d",
                   $time, expected, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return soc_expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [vsoc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [vsoc_pkg::CfgDataW-1:0] cfg_data_i;

  vsoc_in_if  in_if ();
  vsoc_out_if out_if ();

  voltage_soc_estimator_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  soc_scoreboard sb = new();
  int send_idle_pct = 13;
  int recv_idle_pct = 45;
  int stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_soc(out_if.soc_percent);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StallLimit);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic soc_word_t word_of(int v, int t, int c, bit chg);
    soc_word_t w;
    w.voltage_cv       = vsoc_pkg::VinW'(v);
    w.temperature_cdeg = vsoc_pkg::TempW'(t);
    w.current_ma       = vsoc_pkg::CurW'(c);
    w.is_charging      = chg;
    return w;
  endfunction

  function automatic soc_word_t random_word();
    soc_word_t w;
    int r;
    r = $urandom_range(99);
    w.voltage_cv = (r < 80) ? vsoc_pkg::VinW'($urandom_range(1250, 1760))
                            : vsoc_pkg::VinW'($urandom);
    r = $urandom_range(99);
    if (r < 70) begin
      w.temperature_cdeg = vsoc_pkg::TempW'($urandom_range(1500, 3500));
    end else if (r < 90) begin
      w.temperature_cdeg = vsoc_pkg::TempW'($urandom_range(0, 8000));
    end else begin
      w.temperature_cdeg = vsoc_pkg::TempW'($urandom);
    end
    r = $urandom_range(99);
    if (r < 60) begin
      w.current_ma = vsoc_pkg::CurW'($urandom_range(0, 300));
    end else if (r < 85) begin
      w.current_ma = vsoc_pkg::CurW'($urandom_range(0, 2000));
    end else begin
      w.current_ma = vsoc_pkg::CurW'($urandom);
    end
    w.is_charging = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic send_word(soc_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.voltage_cv       <= w.voltage_cv;
    in_if.temperature_cdeg <= w.temperature_cdeg;
    in_if.current_ma       <= w.current_ma;
    in_if.is_charging      <= w.is_charging;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(w);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_cfg(int limit, int gain, int step, int tco);
    int vals[4];
    vals = '{limit, gain, step, tco};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= vsoc_pkg::CfgIdxW'(i);
      cfg_data_i <= vsoc_pkg::CfgDataW'(vals[i]);
      sb.set_reg(vsoc_pkg::cfg_idx_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= vsoc_pkg::CfgIdleLimit;
    cfg_data_i             <= '0;
    in_if.valid            <= 1'b0;
    in_if.voltage_cv       <= '0;
    in_if.temperature_cdeg <= '0;
    in_if.current_ma       <= '0;
    in_if.is_charging      <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hold before the first estimate, then both table ends before priming.
    send_word(word_of(1500, 2500, 65535, 1'b0));
    send_word(word_of(1680, 2500, 0, 1'b0));
    send_word(word_of(1296, 2500, 0, 1'b0));
    send_word(word_of(0, 65535, 250, 1'b0));
    send_word(word_of(65535, 0, 65535, 1'b1));
    // First interpolation lands exactly on a table point.
    send_word(word_of(1584, 2500, 0, 1'b0));
    send_word(word_of(1700, 2500, 100, 1'b1));
    send_word(word_of(1700, 2500, 100, 1'b1));
    send_word(word_of(1300, 2500, 200, 1'b0));
    send_word(word_of(1300, 2500, 200, 1'b0));
    send_word(word_of(1500, 0, 0, 1'b0));
    send_word(word_of(1500, 65535, 0, 1'b1));
    send_word(word_of(1500, 2500, 251, 1'b0));
    send_word(word_of(1405, 2500, 65535, 1'b1));
    send_word(word_of(1716, 2500, 65535, 1'b1));
    send_word(word_of(1550, 2500, 0, 1'b1));
    send_word(word_of(1550, 2500, 0, 1'b1));
    send_word(word_of(65535, 65535, 65535, 1'b1));
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      if (p < 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 45;
      end else if (p < 6) begin
        send_idle_pct = 45;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: program_cfg(0, 256, 0, 0);
        1: program_cfg(65535, 511, 32767, 1023);
        2: program_cfg(250, 128, 256, 98);
        3: program_cfg(0, 0, 25600, 1023);
        default: program_cfg($urandom_range(0, 1500), $urandom_range(0, 511),
                             $urandom_range(0, 1024), $urandom_range(0, 1023));
      endcase
      for (int n = 0; n < WordsPerPhase; n++) begin
        send_word(random_word());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
